FILE: design/tkrn_pkg.sv
// Shared constants, types and discount table for the top-k recall/NDCG scorer.
package tkrn_pkg;

   localparam int TOP_DEPTH      = 100;
   localparam int MAX_ITEMS      = 65536;
   localparam int RECALL_K_SMALL = 20;
   localparam int RECALL_K_LARGE = 50;

   localparam int SCORE_W = 32;
   localparam int KEY_W   = SCORE_W + 1;
   localparam int METRIC_W = 17;
   localparam int FRAC_W   = 16;
   localparam int DISC_W   = 25;
   localparam int IDX_W    = $clog2(TOP_DEPTH);
   localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
   localparam int HIT_W    = $clog2(TOP_DEPTH + 1);
   localparam int ACC_W    = DISC_W + $clog2(TOP_DEPTH + 1);
   localparam int NUM_W    = ACC_W + FRAC_W + 1;
   localparam int DSTEP_W  = $clog2(NUM_W + 1);

   typedef logic [DISC_W-1:0] disc_table_type [TOP_DEPTH];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SEL_RECALL_SMALL,
      SEL_RECALL_LARGE,
      SEL_NDCG
   } div_sel_type;

   typedef struct packed {
      logic              insert;
      logic              scan;
      logic [IDX_W-1:0]  rank;
      logic              div_start;
      logic              div_store;
      div_sel_type       div_sel;
      logic              clear;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   // disc[r] = 1/log2(r+2) in Q1.24, log2 by repeated squaring (30 frac bits)
   function automatic disc_table_type build_disc();
      disc_table_type t;
      logic [63:0] n;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] lg;
      logic [63:0] q;
      logic [63:0] num_d;
      logic [63:0] rem;
      int e;
      for (int r = 0; r < TOP_DEPTH; r++) begin
         n = 64'(r + 2);
         e = 0;
         for (int b = 0; b < 63; b++) begin
            if ((n >> (b + 1)) != 64'd0) e = b + 1;
         end
         x = (n << 30) >> e;
         frac = 64'd0;
         for (int b = 0; b < 30; b++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30)) begin
               x = x >> 1;
               frac = frac | 64'd1;
            end
         end
         lg = (64'(e) << 30) | frac;
         // long division of the rounded numerator by lg
         num_d = (64'd1 << 54) + (lg >> 1);
         q = 64'd0;
         rem = 64'd0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num_d[b]};
            if (rem >= lg) begin
               rem = rem - lg;
               q[b] = 1'b1;
            end
         end
         t[r] = q[DISC_W-1:0];
      end
      return t;
   endfunction

   localparam disc_table_type DISC_TABLE = build_disc();

endpackage

FILE: design/tkrn_if.sv
// Valid/ready channel interfaces for score words and metric words.
interface tkrn_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] item_score;
   logic        is_excluded;
   logic        is_relevant;
   logic        last_item;
   modport source (output valid, item_score, is_excluded, is_relevant, last_item,
                   input ready);
   modport sink   (input valid, item_score, is_excluded, is_relevant, last_item,
                   output ready);
endinterface

interface tkrn_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] recall_at_20;
   logic [16:0] recall_at_50;
   logic [16:0] ndcg_at_100;
   logic        result_valid;
   modport source (output valid, recall_at_20, recall_at_50, ndcg_at_100, result_valid,
                   input ready);
   modport sink   (input valid, recall_at_20, recall_at_50, ndcg_at_100, result_valid,
                   output ready);
endinterface

FILE: design/tkrn_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module tkrn_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tkrn_pkg::NUM_W-1:0] dividend,
   input  logic [tkrn_pkg::ACC_W-1:0] divisor,
   output logic                       done,
   output logic [tkrn_pkg::NUM_W-1:0] quotient
);
   import tkrn_pkg::*;

   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [ACC_W-1:0]   rem_ff, rem_in;
   logic [ACC_W-1:0]   den_ff, den_in;
   logic [DSTEP_W-1:0] cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [ACC_W:0]     trial;
   logic [ACC_W:0]     diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = DSTEP_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == DSTEP_W'(1));
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[ACC_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ACC_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: design/tkrn_ctrl.sv
// Sequencer: streaming insert, rank scan, three divides, result hand-off.
module tkrn_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_last,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tkrn_pkg::dp_status_type    status,
   output tkrn_pkg::dp_cmd_type       cmd
);
   import tkrn_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rank_ff, rank_in;
   div_sel_type      sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      rank_in  = rank_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            rank_in = '0;
            sel_in  = SEL_RECALL_SMALL;
            if (req_valid && req_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rank_in = rank_ff + 1'b1;
            if (rank_ff == IDX_W'(TOP_DEPTH - 1)) state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               case (sel_ff)
                  SEL_RECALL_SMALL: begin
                     sel_in = SEL_RECALL_LARGE;
                     state_in = ST_DIV_LOAD;
                  end
                  SEL_RECALL_LARGE: begin
                     sel_in = SEL_NDCG;
                     state_in = ST_DIV_LOAD;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_RESP);
      cmd.insert    = (state_ff == ST_IDLE) && req_valid;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.rank      = rank_ff;
      cmd.div_start = (state_ff == ST_DIV_LOAD);
      cmd.div_store = (state_ff == ST_DIV_WAIT) && status.div_done;
      cmd.div_sel   = sel_ff;
      cmd.clear     = (state_ff == ST_RESP) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rank_ff  <= '0;
         sel_ff   <= SEL_RECALL_SMALL;
      end else begin
         state_ff <= state_in;
         rank_ff  <= rank_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

FILE: design/tkrn_dp.sv
// Datapath: sorted insertion list, counters, scan accumulators, metric divides.
module tkrn_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tkrn_pkg::dp_cmd_type          cmd,
   output tkrn_pkg::dp_status_type       status,
   input  logic [31:0]                   item_score,
   input  logic                          is_excluded,
   input  logic                          is_relevant,
   output logic [tkrn_pkg::METRIC_W-1:0] recall_at_20,
   output logic [tkrn_pkg::METRIC_W-1:0] recall_at_50,
   output logic [tkrn_pkg::METRIC_W-1:0] ndcg_at_100,
   output logic                          result_valid
);
   import tkrn_pkg::*;

   logic [KEY_W-1:0] key_ff [TOP_DEPTH];
   logic [KEY_W-1:0] key_in [TOP_DEPTH];
   logic [TOP_DEPTH-1:0] vld_ff, vld_in;
   logic [TOP_DEPTH-1:0] rel_ff, rel_in;
   logic [TOP_DEPTH-1:0] ge;
   logic [KEY_W-1:0] new_key;

   logic [CNT_W-1:0] item_cnt_ff, item_cnt_in;
   logic [CNT_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic             ovf_ff, ovf_in;
   logic             take;

   logic [HIT_W-1:0] hs_ff, hs_in, hl_ff, hl_in;
   logic [ACC_W-1:0] dcg_ff, dcg_in, ideal_ff, ideal_in;
   logic [METRIC_W-1:0] r20_ff, r20_in, r50_ff, r50_in, ndcg_ff, ndcg_in;
   logic             head_hit;
   logic [DISC_W-1:0] disc;

   logic [ACC_W-1:0] num, den;
   logic [NUM_W-1:0] dividend, quotient;
   logic [CNT_W-1:0] ks, kl;
   logic [METRIC_W-1:0] q_sat;
   logic             div_done;

   assign new_key = is_excluded ? '0 : KEY_W'({1'b0, item_score ^ 32'h8000_0000}) + 1'b1;
   assign take    = cmd.insert && (item_cnt_ff < CNT_W'(MAX_ITEMS));

   // insertion chain: each slot keeps, takes the new key, or takes its upper neighbor
   always_comb begin
      for (int i = 0; i < TOP_DEPTH; i++) begin
         ge[i] = vld_ff[i] && (key_ff[i] >= new_key);
      end
      for (int i = 0; i < TOP_DEPTH; i++) begin
         key_in[i] = key_ff[i];
         vld_in[i] = vld_ff[i];
         rel_in[i] = rel_ff[i];
         if (cmd.clear) begin
            vld_in[i] = 1'b0;
            rel_in[i] = 1'b0;
         end else if (take) begin
            if (!ge[i]) begin
               if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                  key_in[i] = new_key;
                  vld_in[i] = 1'b1;
                  rel_in[i] = is_relevant;
               end else begin
                  key_in[i] = key_ff[(i == 0) ? 0 : i - 1];
                  vld_in[i] = vld_ff[(i == 0) ? 0 : i - 1];
                  rel_in[i] = rel_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.scan) begin
            // walk the list toward slot 0 so the scan reads a fixed slot
            if (i == TOP_DEPTH - 1) begin
               vld_in[i] = 1'b0;
               rel_in[i] = 1'b0;
            end else begin
               vld_in[i] = vld_ff[(i == TOP_DEPTH - 1) ? i : i + 1];
               rel_in[i] = rel_ff[(i == TOP_DEPTH - 1) ? i : i + 1];
            end
         end
      end
   end

   always_comb begin
      item_cnt_in = item_cnt_ff;
      rel_cnt_in  = rel_cnt_ff;
      ovf_in      = ovf_ff;
      if (cmd.clear) begin
         item_cnt_in = '0;
         rel_cnt_in  = '0;
         ovf_in      = 1'b0;
      end else if (cmd.insert) begin
         if (take) begin
            item_cnt_in = item_cnt_ff + 1'b1;
            if (is_relevant && rel_cnt_ff < CNT_W'(MAX_ITEMS)) rel_cnt_in = rel_cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   assign disc     = DISC_TABLE[cmd.rank];
   assign head_hit = vld_ff[0] && rel_ff[0];

   always_comb begin
      hs_in    = hs_ff;
      hl_in    = hl_ff;
      dcg_in   = dcg_ff;
      ideal_in = ideal_ff;
      if (cmd.clear) begin
         hs_in    = '0;
         hl_in    = '0;
         dcg_in   = '0;
         ideal_in = '0;
      end else if (cmd.scan) begin
         if (head_hit) begin
            if (32'(cmd.rank) < 32'(RECALL_K_SMALL)) hs_in = hs_ff + 1'b1;
            if (32'(cmd.rank) < 32'(RECALL_K_LARGE)) hl_in = hl_ff + 1'b1;
            dcg_in = dcg_ff + ACC_W'(disc);
         end
         if (CNT_W'(cmd.rank) < rel_cnt_ff) ideal_in = ideal_ff + ACC_W'(disc);
      end
   end

   assign ks = (CNT_W'(RECALL_K_SMALL) < rel_cnt_ff) ? CNT_W'(RECALL_K_SMALL) : rel_cnt_ff;
   assign kl = (CNT_W'(RECALL_K_LARGE) < rel_cnt_ff) ? CNT_W'(RECALL_K_LARGE) : rel_cnt_ff;

   always_comb begin
      case (cmd.div_sel)
         SEL_RECALL_SMALL: begin
            num = ACC_W'(hs_ff);
            den = ACC_W'(ks);
         end
         SEL_RECALL_LARGE: begin
            num = ACC_W'(hl_ff);
            den = ACC_W'(kl);
         end
         default: begin
            num = dcg_ff;
            den = ideal_ff;
         end
      endcase
   end

   // round half up: (num * 2^16 + den / 2) / den
   assign dividend = {1'b0, num, {FRAC_W{1'b0}}} + NUM_W'(den >> 1);

   tkrn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (den),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.div_done = div_done;

   always_comb begin
      if (den == '0) q_sat = '0;
      else if (quotient > NUM_W'(1 << FRAC_W)) q_sat = METRIC_W'(1 << FRAC_W);
      else q_sat = quotient[METRIC_W-1:0];
   end

   always_comb begin
      r20_in  = r20_ff;
      r50_in  = r50_ff;
      ndcg_in = ndcg_ff;
      if (cmd.div_store) begin
         case (cmd.div_sel)
            SEL_RECALL_SMALL: r20_in  = q_sat;
            SEL_RECALL_LARGE: r50_in  = q_sat;
            default:          ndcg_in = q_sat;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_DEPTH; i++) key_ff[i] <= key_in[i];
      r20_ff  <= r20_in;
      r50_ff  <= r50_in;
      ndcg_ff <= ndcg_in;
      if (reset) begin
         vld_ff      <= '0;
         rel_ff      <= '0;
         item_cnt_ff <= '0;
         rel_cnt_ff  <= '0;
         ovf_ff      <= 1'b0;
         hs_ff       <= '0;
         hl_ff       <= '0;
         dcg_ff      <= '0;
         ideal_ff    <= '0;
      end else begin
         vld_ff      <= vld_in;
         rel_ff      <= rel_in;
         item_cnt_ff <= item_cnt_in;
         rel_cnt_ff  <= rel_cnt_in;
         ovf_ff      <= ovf_in;
         hs_ff       <= hs_in;
         hl_ff       <= hl_in;
         dcg_ff      <= dcg_in;
         ideal_ff    <= ideal_in;
      end
   end

   assign result_valid = !ovf_ff && (rel_cnt_ff != '0);
   assign recall_at_20 = result_valid ? r20_ff  : '0;
   assign recall_at_50 = result_valid ? r50_ff  : '0;
   assign ndcg_at_100  = result_valid ? ndcg_ff : '0;
endmodule

FILE: design/topk_recall_ndcg_scorer.sv
// Top level of the streaming top-k recall@20/recall@50/NDCG@100 scorer.
// Score words are taken one per cycle, while the block is idle, into a 100-slot
// sorted insertion chain (stable descending order, excluded items lowest). The
// word flagged last_item starts the finish: a scan over the ranks, then three
// divides on one shared bit-serial divider; the metric word is then offered and
// held until taken. No score word is accepted from the last item until the
// metric word is taken; the block then starts clean for the next vector.
module topk_recall_ndcg_scorer (
   input logic     clock,
   input logic     reset,
   tkrn_req_if.sink   req_ch,
   tkrn_rsp_if.source rsp_ch
);
   import tkrn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tkrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_item),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkrn_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .item_score   (req_ch.item_score),
      .is_excluded  (req_ch.is_excluded),
      .is_relevant  (req_ch.is_relevant),
      .recall_at_20 (rsp_ch.recall_at_20),
      .recall_at_50 (rsp_ch.recall_at_50),
      .ndcg_at_100  (rsp_ch.ndcg_at_100),
      .result_valid (rsp_ch.result_valid)
   );
endmodule
